@@ src/wlru_pkg.sv @@
// Shared types and constants for the weighted LRU victim selector.
`timescale 1ns / 1ps
package wlru_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int VIDX_W          = 12;
    localparam int Q_ONE           = 65536;
    localparam int FIFO_DEPTH_DEF  = 4;

    localparam logic [2:0] REG_RECENCY_WINDOW = 3'd0;
    localparam logic [2:0] REG_SIZE_SCALE     = 3'd1;
    localparam logic [2:0] REG_WEIGHT_RECENCY = 3'd2;
    localparam logic [2:0] REG_WEIGHT_REUSE   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_SIZE    = 3'd4;

    // One classified entry on its way from the front end to the scorer.
    typedef struct packed {
        logic [31:0]       age_mag;
        logic              age_neg;
        logic [31:0]       tokens;
        logic [16:0]       reuse;
        logic              score;
        logic [VIDX_W-1:0] pos;
        logic              last;
        logic              ovf;
    } wlru_entry_t;

    // Configuration values seen by the scorer.
    typedef struct packed {
        logic [31:0] recency_window;
        logic [31:0] size_scale;
        logic [15:0] weight_recency;
        logic [15:0] weight_reuse;
        logic [15:0] weight_size;
    } wlru_cfg_t;

endpackage

@@ src/weighted_lru_victim_select_core.sv @@
// Top level of the weighted LRU victim selector with its register file.
`timescale 1ns / 1ps
// Usage: stream a run of cache entries on the s_ channel, one transfer per
// entry; s_tlast marks the final entry of the run. The present time is taken
// from the first entry of each run. At the end of a run one transfer leaves on
// the m_ channel with the victim's position, a found flag and an overflow flag.
// Entries beyond MAX_ENTRIES in a run are not scored.
// The scorer takes one entry at a time from the queue: a scored entry goes
// through the two bit-serial normalizing dividers (16 steps), a multiply, a
// sum and a compare; a pinned or out-of-range entry goes straight to the
// compare. A four-entry queue lets the input take bursts while the scorer
// works. Once the last entry of a run is compared, the result is registered
// and m_tvalid rises. Reset (aresetn low, synchronous) empties the queue,
// starts a new run and loads the registers with window 1, scale 1 and all
// weights 1.0 (Q4.12). If the receiver stalls, the result waits in the output
// register; the scorer then holds at the next end of run and the queue fills
// up before s_tready falls. The user must write the registers over APB only
// while the block is idle; the block itself does not enforce this.
module weighted_lru_victim_select_core
    import wlru_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] current_time, [63:32] access_time, [95:64] token_count,
    // [112:96] reuse_prob, [119:113] zero
    input  logic [119:0] s_tdata,
    // [0] is_pinned
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [11:0] victim_index, [15:12] zero
    output logic [15:0]  m_tdata,
    // [0] found, [1] run_overflow
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    wlru_cfg_t         cfg_reg;
    logic              push, fifo_full, fifo_empty, pop;
    wlru_entry_t       push_entry, pop_entry;
    logic [VIDX_W-1:0] out_index;
    logic              out_found, out_ovf;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.recency_window <= 32'd1;
            cfg_reg.size_scale     <= 32'd1;
            cfg_reg.weight_recency <= 16'd4096;
            cfg_reg.weight_reuse   <= 16'd4096;
            cfg_reg.weight_size    <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_RECENCY_WINDOW: cfg_reg.recency_window <= pwdata;
                REG_SIZE_SCALE:     cfg_reg.size_scale     <= pwdata;
                REG_WEIGHT_RECENCY: cfg_reg.weight_recency <= pwdata[15:0];
                REG_WEIGHT_REUSE:   cfg_reg.weight_reuse   <= pwdata[15:0];
                REG_WEIGHT_SIZE:    cfg_reg.weight_size    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RECENCY_WINDOW: prdata = cfg_reg.recency_window;
            REG_SIZE_SCALE:     prdata = cfg_reg.size_scale;
            REG_WEIGHT_RECENCY: prdata = {16'd0, cfg_reg.weight_recency};
            REG_WEIGHT_REUSE:   prdata = {16'd0, cfg_reg.weight_reuse};
            REG_WEIGHT_SIZE:    prdata = {16'd0, cfg_reg.weight_size};
            default:            prdata = '0;
        endcase
    end

    wlru_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_now     (s_tdata[31:0]),
        .in_access  (s_tdata[63:32]),
        .in_tokens  (s_tdata[95:64]),
        .in_reuse   (s_tdata[112:96]),
        .in_pinned  (s_tuser[0]),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .fifo_full  (fifo_full)
    );

    wlru_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (fifo_empty)
    );

    wlru_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_entry (pop_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_found  (out_found),
        .out_ovf    (out_ovf)
    );

    assign m_tdata = {4'd0, out_index};
    assign m_tuser = {out_ovf, out_found};

endmodule

@@ src/wlru_front.sv @@
// Front end: accepts entries, tracks run position and present time, computes the age.
`timescale 1ns / 1ps
module wlru_front
    import wlru_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_now,
    input  logic [31:0] in_access,
    input  logic [31:0] in_tokens,
    input  logic [16:0] in_reuse,
    input  logic        in_pinned,
    input  logic        in_last,
    output logic        push,
    output wlru_entry_t push_entry,
    input  logic        fifo_full
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 2);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      latched_time_reg;
    logic [31:0]      time_use;
    logic [32:0]      age;
    logic [32:0]      age_abs;
    logic             in_range;

    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        time_use = (cnt_reg == '0) ? in_now : latched_time_reg;
        age      = {1'b0, time_use} - {1'b0, in_access};
        age_abs  = age[32] ? (33'd0 - age) : age;
        in_range = cnt_reg < CNT_W'(MAX_ENTRIES);
        if (in_last) begin
            cnt_next = '0;
        end else if (in_range) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = CNT_W'(MAX_ENTRIES + 1);
        end
        push_entry.age_mag = age_abs[31:0];
        push_entry.age_neg = age[32];
        push_entry.tokens  = in_tokens;
        push_entry.reuse   = in_reuse;
        push_entry.score   = in_range && !in_pinned;
        push_entry.pos     = VIDX_W'(cnt_reg);
        push_entry.last    = in_last;
        push_entry.ovf     = !in_range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg          <= '0;
            latched_time_reg <= '0;
        end else if (push) begin
            cnt_reg <= cnt_next;
            if (cnt_reg == '0) begin
                latched_time_reg <= in_now;
            end
        end
    end

endmodule

@@ src/wlru_fifo.sv @@
// Short queue between the front end and the scorer.
`timescale 1ns / 1ps
module wlru_fifo
    import wlru_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wlru_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output wlru_entry_t pop_entry,
    output logic        empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    wlru_entry_t     mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full      = count_reg == (AW + 1)'(DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/wlru_back.sv @@
// Scorer: normalizes age and size by serial division, weights, and keeps the best entry.
`timescale 1ns / 1ps
module wlru_back
    import wlru_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  wlru_cfg_t         cfg,
    input  logic              fifo_empty,
    input  wlru_entry_t       fifo_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VIDX_W-1:0] out_index,
    output logic              out_found,
    output logic              out_ovf
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_FIN
    } state_t;

    state_t            state_reg;
    wlru_entry_t       ent_reg;
    logic [32:0]       rem_rec_reg, rem_sz_reg;
    logic [15:0]       q_rec_reg, q_sz_reg;
    logic              sat_rec_reg, sat_sz_reg;
    logic [3:0]        step_reg;
    logic [32:0]       prod_rec_reg;
    logic [32:0]       prod_nr_reg, prod_sz_reg;
    logic signed [23:0] pressure_reg;
    logic signed [23:0] best_pressure_reg;
    logic [VIDX_W-1:0] best_pos_reg;
    logic              have_best_reg;
    logic              out_valid_reg;
    logic [VIDX_W-1:0] out_index_reg;
    logic              out_found_reg, out_ovf_reg;

    logic [31:0]       div_rec, div_sz;
    logic [32:0]       sh_rec, sh_sz;
    logic              ge_rec, ge_sz;
    logic [16:0]       rec_val, sz_val, reuse_sat, nonreuse;
    logic signed [35:0] sum;
    logic              take;
    logic              out_free;
    logic              emit;
    logic              have_best_n;
    logic [VIDX_W-1:0] best_pos_n;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_found = out_found_reg;
    assign out_ovf   = out_ovf_reg;
    assign pop       = (state_reg == ST_IDLE) && !fifo_empty;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == ST_FIN) && ent_reg.last && out_free;

    always_comb begin
        div_rec   = (cfg.recency_window == '0) ? 32'd1 : cfg.recency_window;
        div_sz    = (cfg.size_scale == '0) ? 32'd1 : cfg.size_scale;
        sh_rec    = {rem_rec_reg[31:0], 1'b0};
        sh_sz     = {rem_sz_reg[31:0], 1'b0};
        ge_rec    = sh_rec >= {1'b0, div_rec};
        ge_sz     = sh_sz >= {1'b0, div_sz};
        rec_val   = sat_rec_reg ? 17'(Q_ONE) : {1'b0, q_rec_reg};
        sz_val    = sat_sz_reg ? 17'(Q_ONE) : {1'b0, q_sz_reg};
        reuse_sat = (ent_reg.reuse > 17'(Q_ONE)) ? 17'(Q_ONE) : ent_reg.reuse;
        nonreuse  = 17'(Q_ONE) - reuse_sat;
        // The recency product carries the sign of the age.
        sum = (ent_reg.age_neg ? -$signed({3'b000, prod_rec_reg})
                               : $signed({3'b000, prod_rec_reg}))
            + $signed({3'b000, prod_nr_reg}) + $signed({3'b000, prod_sz_reg});
        take        = ent_reg.score && (!have_best_reg || pressure_reg > best_pressure_reg);
        have_best_n = have_best_reg || take;
        best_pos_n  = take ? ent_reg.pos : best_pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            have_best_reg     <= 1'b0;
            best_pressure_reg <= '0;
            best_pos_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && !emit) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!fifo_empty) begin
                        ent_reg     <= fifo_entry;
                        // A value at or above the divisor makes the quotient reach one.
                        sat_rec_reg <= fifo_entry.age_mag >= div_rec;
                        sat_sz_reg  <= fifo_entry.tokens >= div_sz;
                        rem_rec_reg <= {1'b0, fifo_entry.age_mag};
                        rem_sz_reg  <= {1'b0, fifo_entry.tokens};
                        step_reg    <= '0;
                        state_reg   <= fifo_entry.score ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    rem_rec_reg <= ge_rec ? sh_rec - {1'b0, div_rec} : sh_rec;
                    rem_sz_reg  <= ge_sz ? sh_sz - {1'b0, div_sz} : sh_sz;
                    q_rec_reg   <= {q_rec_reg[14:0], ge_rec};
                    q_sz_reg    <= {q_sz_reg[14:0], ge_sz};
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == 4'd15) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_rec_reg <= cfg.weight_recency * rec_val;
                    prod_nr_reg  <= cfg.weight_reuse * nonreuse;
                    prod_sz_reg  <= cfg.weight_size * sz_val;
                    state_reg    <= ST_SUM;
                end
                ST_SUM: begin
                    pressure_reg <= 24'(sum >>> 12);
                    state_reg    <= ST_FIN;
                end
                ST_FIN: begin
                    if (!ent_reg.last) begin
                        if (take) begin
                            best_pressure_reg <= pressure_reg;
                            best_pos_reg      <= ent_reg.pos;
                            have_best_reg     <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_valid_reg     <= 1'b1;
                        out_index_reg     <= have_best_n ? best_pos_n : '0;
                        out_found_reg     <= have_best_n;
                        out_ovf_reg       <= ent_reg.ovf;
                        best_pressure_reg <= '0;
                        best_pos_reg      <= '0;
                        have_best_reg     <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ test/weighted_lru_victim_select_core_tb.sv @@
// Testbench for the weighted LRU victim selector: random and directed runs with a scoreboard.
`timescale 1ns / 1ps
module weighted_lru_victim_select_core_tb
    import wlru_pkg::*;
();

    typedef struct {
        logic [31:0] now;
        logic [31:0] access;
        logic [31:0] tokens;
        logic [16:0] reuse;
        logic        pinned;
        logic        last;
    } cache_entry_t;

    typedef struct {
        logic [11:0] victim;
        logic        found;
        logic        overflow;
    } victim_t;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    cache_entry_t entry_queue[$];
    victim_t      victim_queue[$];
    cache_entry_t in_flight;
    int           errors = 0;
    int           cycles = 0;
    bit           calm = 1'b0;

    // Shadow registers and run state of the selector.
    logic [31:0] cfg_window = 32'd1;
    logic [31:0] cfg_scale = 32'd1;
    logic [15:0] cfg_w_recency = 16'd4096;
    logic [15:0] cfg_w_reuse = 16'd4096;
    logic [15:0] cfg_w_size = 16'd4096;
    longint      top_pressure = 0;
    int          top_position = 0;
    bit          have_top = 1'b0;
    int          run_count = 0;
    logic [31:0] run_time = '0;

    weighted_lru_victim_select_core dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint ratio_q16(longint value, logic [31:0] divisor);
        longint d;
        longint q;
        d = (divisor == 0) ? 1 : longint'(divisor);
        q = (value << 16) / d;
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic longint pressure_of(cache_entry_t e);
        longint age;
        longint rec;
        longint sz;
        longint reuse;
        longint sum;
        age = longint'(run_time) - longint'(e.access);
        rec = ratio_q16((age < 0) ? -age : age, cfg_window);
        if (age < 0) begin
            rec = -rec;
        end
        sz = ratio_q16(longint'(e.tokens), cfg_scale);
        reuse = (e.reuse > 17'd65536) ? 65536 : longint'(e.reuse);
        sum = longint'(cfg_w_recency) * rec + longint'(cfg_w_reuse) * (65536 - reuse)
            + longint'(cfg_w_size) * sz;
        return sum >>> 12;
    endfunction

    task automatic score_entry(cache_entry_t e);
        longint p;
        victim_t v;
        if (run_count == 0) begin
            run_time = e.now;
        end
        if (run_count < MAX_ENTRIES_DEF) begin
            if (!e.pinned) begin
                p = pressure_of(e);
                if (!have_top || p > top_pressure) begin
                    top_pressure = p;
                    top_position = run_count;
                    have_top = 1'b1;
                end
            end
            run_count++;
        end else begin
            run_count = MAX_ENTRIES_DEF + 1;
        end
        if (e.last) begin
            v.victim = have_top ? 12'(top_position) : 12'd0;
            v.found = have_top;
            v.overflow = run_count > MAX_ENTRIES_DEF;
            victim_queue.push_back(v);
            top_pressure = 0;
            top_position = 0;
            have_top = 1'b0;
            run_count = 0;
        end
    endtask

    // Input driver: one transfer per entry, with random idle cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                score_entry(in_flight);
            end
            if (!s_tvalid || s_tready) begin
                if (entry_queue.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
                    in_flight = entry_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, in_flight.reuse, in_flight.tokens,
                                in_flight.access, in_flight.now};
                    s_tuser <= in_flight.pinned;
                    s_tlast <= in_flight.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge aclk) begin
        victim_t v;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (victim_queue.size() == 0) begin
                    $error("unexpected result transfer: victim_index %0d", m_tdata[11:0]);
                    errors++;
                end else begin
                    v = victim_queue.pop_front();
                    if (m_tdata[11:0] !== v.victim) begin
                        $error("victim_index expected %0d actual %0d", v.victim, m_tdata[11:0]);
                        errors++;
                    end
                    if (m_tuser[0] !== v.found) begin
                        $error("found expected %0d actual %0d", v.found, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== v.overflow) begin
                        $error("run_overflow expected %0d actual %0d", v.overflow, m_tuser[1]);
                        errors++;
                    end
                end
            end
            m_tready <= calm || $urandom_range(99) >= 7;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_RECENCY_WINDOW: cfg_window = value;
            REG_SIZE_SCALE:     cfg_scale = value;
            REG_WEIGHT_RECENCY: cfg_w_recency = value[15:0];
            REG_WEIGHT_REUSE:   cfg_w_reuse = value[15:0];
            REG_WEIGHT_SIZE:    cfg_w_size = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [31:0] window, logic [31:0] scale,
                               logic [15:0] wr, logic [15:0] wu, logic [15:0] ws);
        reg_write(REG_RECENCY_WINDOW, window);
        reg_write(REG_SIZE_SCALE, scale);
        reg_write(REG_WEIGHT_RECENCY, {16'd0, wr});
        reg_write(REG_WEIGHT_REUSE, {16'd0, wu});
        reg_write(REG_WEIGHT_SIZE, {16'd0, ws});
    endtask

    // Checked on the falling edge so that the driver's updates have settled.
    task automatic drain();
        while (entry_queue.size() > 0 || s_tvalid || victim_queue.size() > 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_entry(logic [31:0] now, logic [31:0] access, logic [31:0] tokens,
                             logic [16:0] reuse, logic pinned, logic last);
        cache_entry_t e;
        e.now = now;
        e.access = access;
        e.tokens = tokens;
        e.reuse = reuse;
        e.pinned = pinned;
        e.last = last;
        entry_queue.push_back(e);
    endtask

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 64);
            3: return $urandom_range(1, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // Random runs of one to eight entries; access times cluster around the run's time.
    task automatic add_random_runs(int count);
        int len;
        logic [31:0] now;
        logic [31:0] access;
        logic [31:0] tokens;
        logic [16:0] reuse;
        for (int n = 0; n < count; n += len) begin
            len = $urandom_range(1, 8);
            now = $urandom;
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(3))
                    0: access = now - $urandom_range(0, 2 * cfg_window + 4);
                    1: access = now + $urandom_range(0, 2 * cfg_window + 4);
                    default: access = $urandom;
                endcase
                case ($urandom_range(2))
                    0: tokens = $urandom_range(0, 2 * cfg_scale + 4);
                    default: tokens = $urandom;
                endcase
                reuse = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
                add_entry(k == 0 ? now : $urandom, access, tokens, reuse,
                          $urandom_range(3) == 0, k == len - 1);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single entries, field extremes, negative age, ties, all pinned.
        add_entry(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 17'd0, 1'b0, 1'b1);
        add_entry(32'd0, 32'hFFFF_FFFF, 32'd0, 17'd65536, 1'b0, 1'b1);
        add_entry(32'd100, 32'd50, 32'd3, 17'h1FFFF, 1'b0, 1'b0);
        add_entry(32'd7, 32'd50, 32'd3, 17'h1FFFF, 1'b0, 1'b0);
        add_entry(32'd7, 32'd200, 32'd0, 17'd65536, 1'b0, 1'b1);
        add_entry(32'd10, 32'd5, 32'd2, 17'd100, 1'b0, 1'b0);
        add_entry(32'd10, 32'd5, 32'd2, 17'd100, 1'b0, 1'b0);
        add_entry(32'd10, 32'd5, 32'd2, 17'd100, 1'b0, 1'b1);
        add_entry(32'd1, 32'd0, 32'd9, 17'd0, 1'b1, 1'b0);
        add_entry(32'd1, 32'd0, 32'd9, 17'd0, 1'b1, 1'b1);
        add_entry(32'd1, 32'd0, 32'd9, 17'd0, 1'b1, 1'b0);
        add_entry(32'd1, 32'd0, 32'd9, 17'd0, 1'b0, 1'b1);
        drain();

        add_random_runs(20);
        drain();

        load_config(32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        add_random_runs(150);
        drain();

        calm = 1'b1;
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random_runs(300);
        drain();
        calm = 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            load_config(pick_wide(), pick_wide(), 16'($urandom), 16'($urandom),
                        16'($urandom));
            add_random_runs(250);
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
